### rtl/core/wnll_pkg.sv
// ----------------------------------------------------------------------------
// wnll_pkg: shared types and constants for the weighted NLL loss block
// Payload structs, register indexes, command and mode codes, divider widths.
// ----------------------------------------------------------------------------
package wnll_pkg;

  localparam int MAX_CLASSES_DEF = 256;

  // iterative divider: Q.32 magnitude over Q.16 weight sum
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 36;

  localparam int WEIGHT_W = 18;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 18'h10000;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // reduction modes; the reserved code behaves as mean
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SUM  = 2'd1;
  localparam logic [1:0] MODE_MEAN = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_REDUCTION_MODE = 3'd0;
  localparam logic [2:0] REG_IGNORE_ENABLE  = 3'd1;
  localparam logic [2:0] REG_IGNORE_LABEL   = 3'd2;
  localparam logic [2:0] REG_WEIGHTS_ENABLE = 3'd3;
  localparam logic [2:0] REG_CLASS_COUNT    = 3'd4;

  typedef struct packed {
    logic                cmd;
    logic signed [15:0]  label;
    logic signed [23:0]  score;
    logic [WEIGHT_W-1:0] weight_value;
    logic                last_sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0] loss;
    logic               label_error;
    logic               is_reduced;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/wnll_wmem.sv
// ----------------------------------------------------------------------------
// wnll_wmem: class weight table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wnll_wmem #(
  parameter int DEPTH = wnll_pkg::MAX_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [wnll_pkg::WEIGHT_W-1:0] wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [wnll_pkg::WEIGHT_W-1:0] rdata
);

  logic [wnll_pkg::WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/wnll_div.sv
// ----------------------------------------------------------------------------
// wnll_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module wnll_div (
  input  logic               clk,
  input  logic               rst,
  input  wnll_pkg::div_req_t req,
  output wnll_pkg::div_rsp_t rsp
);

  localparam int NW    = wnll_pkg::DIV_NUM_W;
  localparam int DW    = wnll_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [NW-1:0]    quo;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
    fits  = !diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/core/weighted_nll_loss_reduce.sv
// ----------------------------------------------------------------------------
// weighted_nll_loss_reduce: weighted negative log-likelihood loss
// Per-sample loss with optional sum or weighted-mean reduction over a batch.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): cmd load writes one entry of
//   the class weight table, cmd sample feeds one label and its log-prob.
//   result channel (result_valid/result_stall/result): one loss per sample
//   in mode none, one reduced loss on the last sample in sum or mean mode.
//   cfg_we/cfg_index/cfg_data write the control registers; the user must
//   do so only while idle, which the block itself does not enforce.
// Sequencing (one transaction in flight, item_stall high while busy): load
//   writes in idle. sample: weight read, multiply, accumulate. per-sample or
//   sum result: then magnitude, rounding; mean: magnitude, 64-step divider.
// A finished result sits in the output register; the next item is taken
// meanwhile and only waits at its own result if the receiver still stalls.
// Reset clears accumulators, the error flag and registers; the weight table
// is not cleared and must be loaded before weights are used.
// ----------------------------------------------------------------------------
module weighted_nll_loss_reduce #(
  parameter int MAX_CLASSES = wnll_pkg::MAX_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wnll_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output wnll_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AW = $clog2(MAX_CLASSES);
  localparam int WW = wnll_pkg::WEIGHT_W;
  localparam logic [15:0] CLASS_LIMIT = 16'(MAX_CLASSES);
  localparam logic signed [63:0] LACC_MAX = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] LACC_MIN = -LACC_MAX;
  localparam logic [63:0] ROUND_HALF = 64'd32768;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_MAG, S_ROUND, S_BIAS, S_DIV, S_EMIT
  } state_t;

  state_t state;

  // control registers
  logic [1:0]        reduction_mode;
  logic              ignore_enable;
  logic signed [15:0] ignore_label;
  logic              weights_enable;
  logic [8:0]        class_count;

  // block state
  logic signed [63:0] loss_acc;
  logic [35:0]        weight_acc;
  logic               err_sticky;

  // per-transaction working registers
  logic               contrib;
  logic               last_q;
  logic signed [23:0] score_q;
  logic [WW-1:0]      w_q;
  logic signed [43:0] prod;
  logic [63:0]        mag;
  logic               neg_q;
  logic signed [31:0] res_loss;

  logic item_accept;
  logic is_mean;
  logic [15:0] cc16;
  logic [15:0] limit16;
  logic [15:0] label_u;
  logic load_ok;
  logic in_range;
  logic skip;
  logic mem_we;
  logic mem_re;
  logic [WW-1:0] rdata;
  logic [WW-1:0] w_sel;
  logic signed [24:0] neg_score;
  logic signed [43:0] mult;
  logic signed [63:0] prod_ext;
  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_next;
  logic [36:0]        wsum;
  logic [35:0]        wacc_next;
  logic signed [63:0] mag_src;
  logic [63:0]        rnd;
  logic [63:0]        rounded;
  logic               out_free;

  wnll_pkg::div_req_t div_req;
  wnll_pkg::div_rsp_t div_rsp;

  // signed Q16.16 from a magnitude and sign, saturated to 32 bits
  function automatic logic signed [31:0] sat_q16(input logic [63:0] m, input logic n);
    logic signed [31:0] r;
    if (n) begin
      r = (m > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return r;
  endfunction

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign is_mean     = (reduction_mode != wnll_pkg::MODE_NONE) &&
                       (reduction_mode != wnll_pkg::MODE_SUM);
  assign out_free    = !result_valid || !result_stall;

  always_comb begin
    cc16     = 16'(class_count);
    limit16  = (cc16 < CLASS_LIMIT) ? cc16 : CLASS_LIMIT;
    label_u  = item.label;
    load_ok  = !item.label[15] && (label_u < CLASS_LIMIT);
    in_range = !item.label[15] && (label_u < limit16);
    skip     = ignore_enable && (item.label == ignore_label);
    mem_we   = item_accept && (item.cmd == wnll_pkg::CMD_LOAD) && load_ok;
    mem_re   = item_accept && (item.cmd == wnll_pkg::CMD_SAMPLE);
  end

  wnll_wmem #(
    .DEPTH (MAX_CLASSES)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item.label[AW-1:0]),
    .wdata (item.weight_value),
    .re    (mem_re),
    .raddr (item.label[AW-1:0]),
    .rdata (rdata)
  );

  // datapath arithmetic
  always_comb begin
    if (!contrib) begin
      w_sel = '0;
    end else if (weights_enable) begin
      w_sel = rdata;
    end else begin
      w_sel = wnll_pkg::ONE_Q16;
    end
    neg_score = -$signed({score_q[23], score_q});
    mult      = $signed({1'b0, w_sel}) * neg_score;

    prod_ext = 64'(prod);
    acc_sum  = loss_acc + prod_ext;
    if (acc_sum > LACC_MAX) begin
      acc_next = LACC_MAX;
    end else if (acc_sum < LACC_MIN) begin
      acc_next = LACC_MIN;
    end else begin
      acc_next = acc_sum;
    end
    wsum      = {1'b0, weight_acc} + 37'(w_q);
    wacc_next = wsum[36] ? '1 : wsum[35:0];

    mag_src = (reduction_mode == wnll_pkg::MODE_NONE) ? prod_ext : loss_acc;
    rnd     = mag + ROUND_HALF;
    rounded = {16'h0000, rnd[63:16]};
  end

  always_comb begin
    div_req.start    = (state == S_BIAS);
    div_req.dividend = mag + 64'(weight_acc >> 1);
    div_req.divisor  = weight_acc;
  end

  wnll_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      loss_acc       <= '0;
      weight_acc     <= '0;
      err_sticky     <= 1'b0;
      reduction_mode <= wnll_pkg::MODE_MEAN;
      ignore_enable  <= 1'b0;
      ignore_label   <= '0;
      weights_enable <= 1'b0;
      class_count    <= 9'd256;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wnll_pkg::REG_REDUCTION_MODE: reduction_mode <= cfg_data[1:0];
          wnll_pkg::REG_IGNORE_ENABLE:  ignore_enable  <= cfg_data[0];
          wnll_pkg::REG_IGNORE_LABEL:   ignore_label   <= $signed(cfg_data);
          wnll_pkg::REG_WEIGHTS_ENABLE: weights_enable <= cfg_data[0];
          wnll_pkg::REG_CLASS_COUNT:    class_count    <= cfg_data[8:0];
          default: ;
        endcase
      end

      // in S_EMIT the valid flag is set below
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_accept && item.cmd == wnll_pkg::CMD_SAMPLE) begin
            contrib <= !skip && in_range;
            score_q <= item.score;
            last_q  <= item.last_sample;
            if (!skip && !in_range) begin
              err_sticky <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mult;
          w_q   <= w_sel;
          state <= S_ACC;
        end
        S_ACC: begin
          loss_acc   <= acc_next;
          weight_acc <= wacc_next;
          if (reduction_mode == wnll_pkg::MODE_NONE || last_q) begin
            state <= S_MAG;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MAG: begin
          neg_q <= mag_src[63];
          mag   <= mag_src[63] ? 64'(-mag_src) : 64'(mag_src);
          if (!is_mean) begin
            state <= S_ROUND;
          end else if (weight_acc == '0) begin
            res_loss <= '0;
            state    <= S_EMIT;
          end else begin
            state <= S_BIAS;
          end
        end
        S_ROUND: begin
          res_loss <= sat_q16(rounded, neg_q);
          state    <= S_EMIT;
        end
        S_BIAS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_loss <= sat_q16(div_rsp.quotient, neg_q);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            result.loss        <= res_loss;
            result.label_error <= err_sticky;
            result.is_reduced  <= (reduction_mode != wnll_pkg::MODE_NONE);
            // batch end: accumulators are no longer needed for this result
            if (last_q) begin
              loss_acc   <= '0;
              weight_acc <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider only reports back while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // loss accumulator stays inside its saturation bounds
  a_acc_bounds: assert property (@(posedge clk) disable iff (rst)
    (loss_acc <= LACC_MAX) && (loss_acc >= LACC_MIN))
    else $error("loss accumulator out of bounds");

  // label error is sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err_sticky |=> err_sticky)
    else $error("label error flag dropped");

  // a pending result blocks the next one from overwriting it
  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && result_valid && result_stall |=> (state == S_EMIT))
    else $error("result overwritten while stalled");

endmodule
